@@ rtl/bnrh_pkg.sv @@
// bnrh_pkg: shared constants, handshake state codes and control struct
// for the bus node receive and handshake block
// no dependencies
package bnrh_pkg;

    // subscribable variables default, stream word width and configuration port widths
    localparam int SUB_VARS_DEF = 10;
    localparam int S_TDATA_W    = 64;
    localparam int CFG_DATA_W   = 8;
    localparam int CFG_INDEX_W  = 2;

    // frame identifiers
    localparam logic [10:0] ID_CONTROL     = 11'h040;
    localparam logic [10:0] ID_MOTOR       = 11'h008;
    localparam logic [10:0] ID_SERVO_LIGHT = 11'h010;

    // frame byte codes
    localparam logic [7:0] PREFIX_WRITE = 8'hB0;
    localparam logic [7:0] CMD_STATE    = 8'h01;
    localparam logic [7:0] CMD_LIGHT    = 8'h93;
    localparam logic [7:0] VAR_JOYSTICK = 8'h90;
    localparam logic [7:0] VAR_LIGHT    = 8'h14;
    localparam logic [7:0] VAR_BATTERY  = 8'h0C;
    localparam logic [7:0] REQ_SUB      = 8'h30;
    localparam logic [7:0] REQ_UNSUB    = 8'h31;
    localparam logic [7:0] REQ_LEN      = 8'h08;
    localparam logic [7:0] FIRST_VAR    = 8'h2C;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_GOOD_THR  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_STOP_REP  = 2'd2;

    // handshake state codes; the register may also hold codes loaded by a
    // control frame that are not listed here
    typedef enum logic [7:0] {
        HS_SHUTDOWN = 8'h01,
        HS_INIT     = 8'h10,
        HS_READY    = 8'h20,
        HS_STOPPING = 8'h22,
        HS_STARTING = 8'h23,
        HS_STOPPED  = 8'h24,
        HS_DRIVING  = 8'h25
    } hs_state_t;

    // states at or above this code send the long status frame
    localparam logic [7:0] HS_LONG_MIN = 8'h20;

    typedef struct packed {
        logic       step;
        logic       load;
        logic [7:0] load_value;
        logic       drive;
        logic       shutdown;
        logic       elapsed;
        logic [7:0] power_state;
        logic [7:0] servo_state;
        logic [3:0] stop_limit;
    } hs_ctrl_t;

endpackage

@@ rtl/bnrh_handshake.sv @@
// bnrh_handshake: drive handshake state machine with its stop counter
// depends on bnrh_pkg
module bnrh_handshake (
    input  logic                aclk,
    input  logic                aresetn,
    input  bnrh_pkg::hs_ctrl_t  ctrl,
    output bnrh_pkg::hs_state_t state_next
);
    import bnrh_pkg::*;

    hs_state_t  state_reg;
    logic [3:0] stop_count_reg;
    logic [3:0] stop_count_next;
    logic [3:0] stop_inc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= HS_INIT;
            stop_count_reg <= 4'd0;
        end else begin
            state_reg      <= state_next;
            stop_count_reg <= stop_count_next;
        end
    end

    // saturating stop counter increment
    assign stop_inc = (stop_count_reg == 4'hF) ? stop_count_reg : stop_count_reg + 4'd1;

    always_comb begin
        state_next      = state_reg;
        stop_count_next = stop_count_reg;
        if (ctrl.load) begin
            state_next = hs_state_t'(ctrl.load_value);
        end else if (ctrl.step) begin
            case (state_reg)
                HS_INIT: begin
                    if (ctrl.power_state == 8'(HS_INIT) && ctrl.servo_state == 8'(HS_INIT)
                        && ctrl.elapsed) begin
                        state_next = HS_READY;
                    end
                end
                HS_READY: begin
                    if (ctrl.shutdown) begin
                        state_next = HS_SHUTDOWN;
                    end else if (ctrl.power_state == 8'(HS_READY)
                                 && ctrl.servo_state == 8'(HS_READY) && ctrl.drive) begin
                        state_next = HS_STARTING;
                    end
                end
                HS_STARTING: begin
                    if (ctrl.power_state == 8'(HS_DRIVING)
                        && ctrl.servo_state == 8'(HS_DRIVING)) begin
                        state_next = HS_STOPPED;
                    end
                end
                HS_STOPPED: begin
                    if (ctrl.drive) begin
                        state_next = HS_DRIVING;
                    end else if (stop_inc >= ctrl.stop_limit) begin
                        state_next      = HS_STOPPING;
                        stop_count_next = 4'd0;
                    end else begin
                        stop_count_next = stop_inc;
                    end
                end
                HS_DRIVING: begin
                    if (!ctrl.drive) begin
                        state_next = HS_STOPPED;
                    end
                end
                HS_STOPPING: begin
                    if (ctrl.power_state == 8'(HS_READY) && ctrl.servo_state == 8'(HS_READY)) begin
                        state_next = HS_READY;
                    end
                end
                default: begin
                    state_next = state_reg;
                end
            endcase
        end
    end

endmodule

@@ rtl/bus_node_receive_and_handshake.sv @@
// bus_node_receive_and_handshake: top level of the bus node receive and
// drive handshake block; depends on bnrh_pkg and bnrh_handshake
//
// Takes received frames and 20 ms ticks as words on the s_ stream and
// returns one status word on the m_ stream for every tick; frames update
// the peer module states, joystick, light demand, battery debounce, the
// subscription mask and the handshake state and return nothing. One word
// a cycle is accepted while s_tready is high: a word is held in the input
// register, is worked on by the compare and select logic in front of the
// state and result registers, and a tick's status word is then shown on
// m_ from the result register. s_tready falls only while a tick waits in
// the input register behind a status word that has not been taken.
// Configuration writes take effect at the next edge and are meant for
// times when no word is in flight.
module bus_node_receive_and_handshake #(
    parameter  int SUB_VARS  = bnrh_pkg::SUB_VARS_DEF,
    localparam int M_TDATA_W = ((33 + SUB_VARS + 7) / 8) * 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration write port
    input  logic                             cfg_wr_en,
    input  logic [bnrh_pkg::CFG_INDEX_W-1:0] cfg_wr_index,
    input  logic [bnrh_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    // input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // sender_id[10:0], payload[58:11], user_wants_drive[59],
    // shutdown_ongoing[60], startup_time_elapsed[61], zeros above
    input  logic [bnrh_pkg::S_TDATA_W-1:0]   s_tdata,
    // kind: 0 frame, 1 tick
    input  logic                             s_tuser,
    // status stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // own_state[7:0], joystick_y[15:8], joystick_x[23:16], undervoltage[24],
    // subscribed_mask[25 +: SUB_VARS], light_demand above it, zeros above
    output logic [M_TDATA_W-1:0]             m_tdata,
    // long_frame
    output logic                             m_tuser
);
    import bnrh_pkg::*;

    localparam int IN_W = 62;

    // configuration registers
    logic [7:0] good_thr_reg;
    logic [7:0] debounce_reg;
    logic [3:0] stop_rep_reg;

    // input register
    logic            in_valid_reg;
    logic            in_kind_reg;
    logic [IN_W-1:0] in_data_reg;

    // node state
    logic [7:0]          power_state_reg, power_state_next;
    logic [7:0]          servo_state_reg, servo_state_next;
    logic [7:0]          stick_y_reg, stick_y_next;
    logic [7:0]          stick_x_reg, stick_x_next;
    logic [7:0]          lamp_reg, lamp_next;
    logic [7:0]          low_count_reg, low_count_next;
    logic [7:0]          good_count_reg, good_count_next;
    logic                uv_reg, uv_next;
    logic [SUB_VARS-1:0] subs_reg, subs_next;

    // result register
    logic       out_valid_reg;
    logic [7:0] out_state_reg;
    logic       out_long_reg;
    logic [7:0] out_y_reg;
    logic [7:0] out_x_reg;
    logic       out_uv_reg;
    logic [SUB_VARS-1:0] out_subs_reg;
    logic [7:0] out_lamp_reg;

    // fields of the word in the input register
    logic [10:0] id;
    logic [47:0] payload;
    logic [7:0]  b0, b1, b2, b3, b4, b5;
    logic        drive, shutdown, elapsed;

    logic       advance;
    logic       frame_go;
    logic       tick_go;
    logic [7:0] low_inc, good_inc;
    logic [SUB_VARS-1:0] var_hit;

    hs_ctrl_t  hs_ctrl;
    hs_state_t hs_next;

    assign id       = in_data_reg[10:0];
    assign payload  = in_data_reg[58:11];
    assign drive    = in_data_reg[59];
    assign shutdown = in_data_reg[60];
    assign elapsed  = in_data_reg[61];
    assign b0 = payload[47:40];
    assign b1 = payload[39:32];
    assign b2 = payload[31:24];
    assign b3 = payload[23:16];
    assign b4 = payload[15:8];
    assign b5 = payload[7:0];

    // a frame always moves on; a tick needs room in the result register
    assign advance  = in_valid_reg && (!in_kind_reg || !out_valid_reg || m_tready);
    assign frame_go = advance && !in_kind_reg;
    assign tick_go  = advance && in_kind_reg;
    assign s_tready = !in_valid_reg || advance;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            good_thr_reg <= 8'd137;
            debounce_reg <= 8'd20;
            stop_rep_reg <= 4'd8;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                CFG_GOOD_THR: good_thr_reg <= cfg_wr_data;
                CFG_DEBOUNCE: debounce_reg <= cfg_wr_data;
                CFG_STOP_REP: stop_rep_reg <= cfg_wr_data[3:0];
                default:      ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_kind_reg <= s_tuser;
            in_data_reg <= s_tdata[IN_W-1:0];
        end
    end

    // saturating debounce increments
    assign low_inc  = (low_count_reg == 8'hFF) ? low_count_reg : low_count_reg + 8'd1;
    assign good_inc = (good_count_reg == 8'hFF) ? good_count_reg : good_count_reg + 8'd1;

    // one-hot match of the requested variable against the subscribable range
    always_comb begin
        for (int i = 0; i < SUB_VARS; i++) begin
            var_hit[i] = (b3 == FIRST_VAR + 8'(i));
        end
    end

    // frame decode
    always_comb begin
        power_state_next = power_state_reg;
        servo_state_next = servo_state_reg;
        stick_y_next     = stick_y_reg;
        stick_x_next     = stick_x_reg;
        lamp_next        = lamp_reg;
        low_count_next   = low_count_reg;
        good_count_next  = good_count_reg;
        uv_next          = uv_reg;
        subs_next        = subs_reg;
        if (frame_go) begin
            case (id)
                ID_CONTROL: begin
                    if (b0 == PREFIX_WRITE) begin
                        if (b3 == VAR_JOYSTICK) begin
                            stick_y_next = b4;
                            stick_x_next = b5;
                        end
                        if (b1 == CMD_LIGHT && b4 == VAR_LIGHT) begin
                            lamp_next = b5;
                        end
                    end
                end
                ID_MOTOR: begin
                    if (b0 == PREFIX_WRITE) begin
                        if (b1 == CMD_STATE) begin
                            power_state_next = b2;
                        end
                        // battery sample goes straight into the debounce
                        if (b3 == VAR_BATTERY) begin
                            if (b4 >= good_thr_reg) begin
                                low_count_next  = 8'd0;
                                good_count_next = good_inc;
                                if (good_inc > debounce_reg) begin
                                    uv_next = 1'b0;
                                end
                            end else begin
                                good_count_next = 8'd0;
                                low_count_next  = low_inc;
                                if (low_inc > debounce_reg) begin
                                    uv_next = 1'b1;
                                end
                            end
                        end
                    end
                end
                ID_SERVO_LIGHT: begin
                    if (b0 == PREFIX_WRITE && b1 == CMD_STATE) begin
                        servo_state_next = b2;
                    end
                    if (b0 == REQ_SUB && b1 == REQ_LEN) begin
                        subs_next = subs_reg | var_hit;
                    end
                    if (b0 == REQ_UNSUB && b1 == REQ_LEN) begin
                        subs_next = subs_reg & ~var_hit;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            power_state_reg <= 8'd0;
            servo_state_reg <= 8'd0;
            stick_y_reg     <= 8'd0;
            stick_x_reg     <= 8'd0;
            lamp_reg        <= 8'd0;
            low_count_reg   <= 8'd0;
            good_count_reg  <= 8'd0;
            uv_reg          <= 1'b0;
            subs_reg        <= '0;
        end else begin
            power_state_reg <= power_state_next;
            servo_state_reg <= servo_state_next;
            stick_y_reg     <= stick_y_next;
            stick_x_reg     <= stick_x_next;
            lamp_reg        <= lamp_next;
            low_count_reg   <= low_count_next;
            good_count_reg  <= good_count_next;
            uv_reg          <= uv_next;
            subs_reg        <= subs_next;
        end
    end

    // drive handshake: a control state command loads it, a tick steps it
    always_comb begin
        hs_ctrl.step        = tick_go;
        hs_ctrl.load        = frame_go && id == ID_CONTROL && b0 == PREFIX_WRITE
                              && b1 == CMD_STATE;
        hs_ctrl.load_value  = b2;
        hs_ctrl.drive       = drive;
        hs_ctrl.shutdown    = shutdown;
        hs_ctrl.elapsed     = elapsed;
        hs_ctrl.power_state = power_state_reg;
        hs_ctrl.servo_state = servo_state_reg;
        hs_ctrl.stop_limit  = stop_rep_reg;
    end

    bnrh_handshake u_handshake (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (hs_ctrl),
        .state_next (hs_next)
    );

    // result register: a tick leaves its status word here
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (tick_go) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (tick_go) begin
            out_state_reg <= hs_next;
            out_long_reg  <= (hs_next >= HS_LONG_MIN);
            out_y_reg     <= stick_y_reg;
            out_x_reg     <= stick_x_reg;
            out_uv_reg    <= uv_reg;
            out_subs_reg  <= subs_reg;
            out_lamp_reg  <= lamp_reg;
        end
    end

    // status word packing
    always_comb begin
        m_tdata                      = '0;
        m_tdata[7:0]                 = out_state_reg;
        m_tdata[15:8]                = out_y_reg;
        m_tdata[23:16]               = out_x_reg;
        m_tdata[24]                  = out_uv_reg;
        m_tdata[25 +: SUB_VARS]      = out_subs_reg;
        m_tdata[25 + SUB_VARS +: 8]  = out_lamp_reg;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_long_reg;

endmodule

@@ rtl/bnrh_checker.sv @@
// bnrh_checker: port level assertions for the bus node top level, bound in
// below; depends on bnrh_pkg and bus_node_receive_and_handshake
module bnrh_checker #(
    parameter  int SUB_VARS  = bnrh_pkg::SUB_VARS_DEF,
    localparam int M_TDATA_W = ((33 + SUB_VARS + 7) / 8) * 8
) (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tuser
);
    import bnrh_pkg::*;

    localparam int USED_W = 33 + SUB_VARS;

    // a stalled status word holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("status word changed while stalled");

    // reset empties the result register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("status word shown after reset");

    // long frame flag follows the announced state
    a_long_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser == (m_tdata[7:0] >= HS_LONG_MIN))
        else $error("long frame flag disagrees with state");

    // the input side only backs up behind a stalled status word
    a_ready_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without an output stall");

    // padding bits of the status word stay zero
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata >> USED_W) == '0)
        else $error("status word padding not zero");

endmodule

bind bus_node_receive_and_handshake bnrh_checker #(
    .SUB_VARS (SUB_VARS)
) u_bnrh_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
